// ===== design/planar_to_chunky_pixel_converter_core_assert.svh =====
// assertion macros shared by the checker
`ifndef PLANAR_TO_CHUNKY_PIXEL_CONVERTER_CORE_ASSERT_SVH
`define PLANAR_TO_CHUNKY_PIXEL_CONVERTER_CORE_ASSERT_SVH

// checked only while out of reset
`define P2C_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define P2C_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/p2c_pkg.sv =====
`default_nettype none
package p2c_pkg;

  localparam int P2C_GROUP_PIXELS = 16;
  localparam int P2C_MAX_PLANES   = 8;
  localparam int P2C_NUM_WORDS    = 8;
  localparam int P2C_IDX_W        = $clog2(P2C_GROUP_PIXELS);

  localparam logic [14:0] P2C_ROW_WIDTH_RST = 15'd640;

  typedef enum logic [2:0] {
    MODE_MONO   = 3'd0,
    MODE_PLANE2 = 3'd1,
    MODE_PLANE4 = 3'd2,
    MODE_PLANE8 = 3'd3,
    MODE_RGB565 = 3'd4,
    MODE_XRGB32 = 3'd5
  } p2c_mode_t;

  typedef enum logic {
    CFG_PIXEL_MODE = 1'b0,
    CFG_ROW_WIDTH  = 1'b1
  } p2c_cfg_idx_t;

  // one converted group handed to the serializer
  typedef struct packed {
    logic [P2C_GROUP_PIXELS-1:0][7:0] first;
    logic [7:0]                       second;
    logic [7:0]                       third;
    logic                             single;
  } p2c_group_t;

endpackage
`default_nettype wire

// ===== design/p2c_lane.sv =====
`default_nettype none
module p2c_lane import p2c_pkg::*; #(
  parameter int MAX_PLANES = P2C_MAX_PLANES
) (
  input  logic [2:0]               mode,
  input  logic [P2C_NUM_WORDS-1:0] bits,
  output logic [7:0]               value
);

  logic [P2C_NUM_WORDS-1:0] plane_en;

  always_comb begin
    case (mode)
      MODE_PLANE2: plane_en = 8'h03;
      MODE_PLANE4: plane_en = 8'h0f;
      MODE_PLANE8: plane_en = 8'hff;
      default:     plane_en = 8'h00;
    endcase
    // planes past the configured maximum never contribute
    for (int p = 0; p < P2C_NUM_WORDS; p++) begin
      if (p >= MAX_PLANES) begin
        plane_en[p] = 1'b0;
      end
    end
    if (mode == MODE_MONO) begin
      value = bits[0] ? 8'h00 : 8'hff;
    end else begin
      value = bits & plane_en;
    end
  end

endmodule
`default_nettype wire

// ===== design/p2c_serializer.sv =====
`default_nettype none
module p2c_serializer import p2c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        grp_valid,
  input  p2c_group_t  grp,
  output logic        grp_take,
  input  logic [14:0] row_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_channel_first,
  output logic [7:0]  out_channel_second,
  output logic [7:0]  out_channel_third,
  output logic        out_row_end
);

  localparam logic [P2C_IDX_W-1:0] IDX_LAST = P2C_IDX_W'(P2C_GROUP_PIXELS - 1);

  p2c_group_t           act_r;
  logic                 act_valid_r;
  logic [P2C_IDX_W-1:0] idx_r;
  logic [14:0]          col_r;
  logic [14:0]          col_nxt;
  logic                 out_valid_r;
  logic [7:0]           first_r;
  logic [7:0]           second_r;
  logic [7:0]           third_r;
  logic                 row_end_r;

  logic emit;
  logic last;
  logic done;
  logic act_free;

  always_comb begin
    emit     = act_valid_r && (!out_valid_r || !out_stall);
    // zero width compares as always reached, same as width one
    last     = ({1'b0, col_r} + 16'd1) >= {1'b0, row_width};
    done     = last || act_r.single || (idx_r == IDX_LAST);
    act_free = !act_valid_r || (emit && done);
    grp_take = grp_valid && act_free;
    col_nxt  = last ? 15'd0 : col_r + 15'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      idx_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (grp_take) begin
        act_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (emit && done) begin
        act_valid_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (emit) begin
        col_r       <= col_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      act_r <= grp;
    end
    if (emit) begin
      first_r   <= act_r.first[idx_r];
      second_r  <= act_r.second;
      third_r   <= act_r.third;
      row_end_r <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_first  = first_r;
  assign out_channel_second = second_r;
  assign out_channel_third  = third_r;
  assign out_row_end        = row_end_r;

endmodule
`default_nettype wire

// ===== design/planar_to_chunky_pixel_converter_core.sv =====
// a group passes pending, active and output registers before its first pixel is valid
// throughput: one pixel per cycle unless out_stall; a planar group gives 16 pixels (fewer
//   when a row ends inside it), an rgb565 or xrgb32 word gives one, set by the serializer
// a second group is taken while the previous one is still being serialized
// reset (rst_n low, synchronous): mode mono, row width 640, column zero, all stages empty
`default_nettype none
module planar_to_chunky_pixel_converter_core import p2c_pkg::*; #(
  parameter int MAX_PLANES = P2C_MAX_PLANES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_plane_word_0,
  input  logic [15:0] in_plane_word_1,
  input  logic [15:0] in_plane_word_2,
  input  logic [15:0] in_plane_word_3,
  input  logic [15:0] in_plane_word_4,
  input  logic [15:0] in_plane_word_5,
  input  logic [15:0] in_plane_word_6,
  input  logic [15:0] in_plane_word_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_channel_first,
  output logic [7:0]  out_channel_second,
  output logic [7:0]  out_channel_third,
  output logic        out_row_end
);

  logic [2:0]  pixel_mode_r;
  logic [14:0] row_width_r;

  logic [P2C_NUM_WORDS-1:0][15:0]        words;
  logic [P2C_GROUP_PIXELS-1:0][7:0]      lane_val;
  p2c_group_t                            grp_nxt;
  logic                                  grp_ok;
  p2c_group_t                            pend_r;
  logic                                  pend_valid_r;
  logic                                  pend_take;
  logic                                  in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= MODE_MONO;
      row_width_r  <= P2C_ROW_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIXEL_MODE: pixel_mode_r <= cfg_wdata[2:0];
        CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign words = {in_plane_word_7, in_plane_word_6, in_plane_word_5, in_plane_word_4,
                  in_plane_word_3, in_plane_word_2, in_plane_word_1, in_plane_word_0};

  // one lane per pixel column, msb of the words is pixel 0
  for (genvar i = 0; i < P2C_GROUP_PIXELS; i++) begin : g_lane
    logic [P2C_NUM_WORDS-1:0] col_bits;
    for (genvar p = 0; p < P2C_NUM_WORDS; p++) begin : g_bit
      assign col_bits[p] = words[p][P2C_GROUP_PIXELS-1-i];
    end
    p2c_lane #(.MAX_PLANES(MAX_PLANES)) u_lane (
      .mode  (pixel_mode_r),
      .bits  (col_bits),
      .value (lane_val[i])
    );
  end

  // merge lanes or the truecolor word into one group
  always_comb begin
    grp_ok         = pixel_mode_r inside {[MODE_MONO:MODE_XRGB32]};
    grp_nxt.first  = lane_val;
    grp_nxt.second = 8'h00;
    grp_nxt.third  = 8'h00;
    grp_nxt.single = 1'b0;
    case (pixel_mode_r)
      MODE_RGB565: begin
        grp_nxt.first[0] = {in_plane_word_0[15:11], 3'b000};
        grp_nxt.second   = {in_plane_word_0[10:5], 2'b00};
        grp_nxt.third    = {in_plane_word_0[4:0], 3'b000};
        grp_nxt.single   = 1'b1;
      end
      MODE_XRGB32: begin
        grp_nxt.first[0] = in_plane_word_0[7:0];
        grp_nxt.second   = in_plane_word_1[15:8];
        grp_nxt.third    = in_plane_word_1[7:0];
        grp_nxt.single   = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_stall = pend_valid_r && !pend_take;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      // unused mode codes swallow the transaction
      pend_valid_r <= (pend_valid_r && !pend_take) || (in_acc && grp_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_r <= grp_nxt;
    end
  end

  p2c_serializer u_ser (
    .clk                (clk),
    .rst_n              (rst_n),
    .grp_valid          (pend_valid_r),
    .grp                (pend_r),
    .grp_take           (pend_take),
    .row_width          (row_width_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_first  (out_channel_first),
    .out_channel_second (out_channel_second),
    .out_channel_third  (out_channel_third),
    .out_row_end        (out_row_end)
  );

endmodule
`default_nettype wire

// ===== design/p2c_checker.sv =====
`default_nettype none
`include "planar_to_chunky_pixel_converter_core_assert.svh"
module p2c_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_channel_first,
  input wire logic [7:0] out_channel_second,
  input wire logic [7:0] out_channel_third,
  input wire logic       out_row_end
);

  // stalled result stays offered
  `P2C_ASSERT(a_out_hold_valid, out_valid && out_stall |=> out_valid, "out_valid dropped while stalled")

  // stalled result keeps its payload
  `P2C_ASSERT(a_out_hold_data, out_valid && out_stall |=> $stable({out_channel_first, out_channel_second, out_channel_third, out_row_end}), "stalled payload changed")

  // reset leaves the output empty and the input unstalled
  `P2C_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "stages not empty after reset")

  // input only backs up behind a pixel that is on the output
  `P2C_ASSERT(a_stall_has_output, in_stall && in_valid |=> out_valid, "input stalled with no pixel on the output")

endmodule

bind planar_to_chunky_pixel_converter_core p2c_checker u_p2c_checker (.*);
`default_nettype wire
